>>> rtl/brs_pkg.sv
package brs_pkg;

   localparam int COORD_W    = 19;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = CH_W * NUM_CH;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CFG_W      = 10;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 10'd512;

   localparam logic CSR_IDX_ROWS = 1'b0;
   localparam logic CSR_IDX_COLS = 1'b1;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      logic       en;
      logic [1:0] ch;
   } mac_tag_type;

endpackage

>>> rtl/bilinear_remap_sampler_top.sv
// Bilinear remap sampler.
// req channel: op in tuser selects a pixel load (0) or a sample (1).
//   A load writes one 24-bit pixel into the source image store in the
//   cycle it is accepted and produces no result.
//   A sample checks its fixed-point coordinate, then fetches the four
//   neighbors one at a time through the image store's single read port
//   and blends them on one shared multiplier: per neighbor one weight
//   product and three channel products. req_tready is low while a
//   sample is in work.
// rsp channel: one item per sample, held in an output register. A new
//   item is accepted while a result waits; a finished sample waits until
//   the output register is free, so a stalled receiver stalls the block.
// csr port: source_rows at 0x0, source_cols at 0x4, both reset to 512.
// Reset clears control state and returns the size registers to 512;
//   image contents are undefined until loaded.
module bilinear_remap_sampler_top #(
   parameter int MAX_ROWS  = 512,
   parameter int MAX_COLS  = 512,
   parameter int FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // load_row, load_col, load_blue, load_green, load_red, sample_row, sample_col
   input  logic [brs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // op
   input  logic [0:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_blue, out_green, out_red
   output logic [brs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // outside
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [brs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [brs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [brs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int F      = FRAC_BITS;
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = $clog2(MAX_COLS);
   localparam int MEM_AW = RW + CW;
   localparam int DEPTH  = MAX_ROWS * (1 << CW);
   localparam int WGT_W  = 2 * F + 1;
   localparam int OPB_W  = (F + 1 > brs_pkg::CH_W) ? F + 1 : brs_pkg::CH_W;
   localparam int PROD_W = WGT_W + OPB_W;
   localparam int ACC_W  = 2 * F + brs_pkg::CH_W;
   localparam int CW_C   = brs_pkg::COORD_W;

   localparam logic [F:0]       W_ONE = {1'b1, {F{1'b0}}};
   localparam logic [ACC_W-1:0] RND   = ACC_W'(1) << (2 * F - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_ADDR  = 7'b0000100,
      ST_WGT   = 7'b0001000,
      ST_MAC   = 7'b0010000,
      ST_DRAIN = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [brs_pkg::CFG_W-1:0] source_rows_ff, source_cols_ff;

   logic [CW_C-1:0] samp_row_ff, samp_row_in, samp_col_ff, samp_col_in;
   logic            frame_ff, frame_in;
   logic            outside_ff, outside_in;
   logic [RW-1:0]   r0_ff, r0_in;
   logic [CW-1:0]   c0_ff, c0_in;
   logic [F-1:0]    wr1_ff, wr1_in, wc1_ff, wc1_in;
   logic [1:0]      nb_ff, nb_in, ch_ff, ch_in;
   logic [WGT_W-1:0] weight_ff, weight_in;
   logic [ACC_W-1:0] acc_ff [brs_pkg::NUM_CH];
   logic [ACC_W-1:0] acc_in [brs_pkg::NUM_CH];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [brs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_outside_ff, rsp_outside_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                 req_accept;
   brs_pkg::op_type      req_op;
   logic [31:0]          load_row32, load_col32;
   logic                 mem_wr_en, mem_rd_en;
   logic [MEM_AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [brs_pkg::PIX_W-1:0] mem_rd_data;
   logic [RW-1:0]        rd_row;
   logic [CW-1:0]        rd_col;

   logic [31:0] rows_eff, cols_eff, rows_lim, cols_lim, row_full, col_full;
   logic [F:0]  wr_sel, wc_sel;
   logic [brs_pkg::CH_W-1:0] chan_sel;
   logic [ACC_W-1:0] rnd_sum [brs_pkg::NUM_CH];

   logic [WGT_W-1:0]     mul_a;
   logic [OPB_W-1:0]     mul_b;
   brs_pkg::mac_tag_type mul_tag_in, mul_tag;
   logic [PROD_W-1:0]    mul_prod;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_rows_ff <= brs_pkg::CFG_SIZE_RESET;
         source_cols_ff <= brs_pkg::CFG_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[2] == brs_pkg::CSR_IDX_ROWS) begin
            source_rows_ff <= csr_pwdata[brs_pkg::CFG_W-1:0];
         end else begin
            source_cols_ff <= csr_pwdata[brs_pkg::CFG_W-1:0];
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == brs_pkg::CSR_IDX_ROWS) ?
                       brs_pkg::CSR_DATA_W'(source_rows_ff) :
                       brs_pkg::CSR_DATA_W'(source_cols_ff);

   // input side and pixel loads
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = brs_pkg::op_type'(req_tuser[0]);
   assign load_row32 = 32'(req_tdata[8:0]);
   assign load_col32 = 32'(req_tdata[17:9]);

   assign mem_wr_en   = req_accept && (req_op == brs_pkg::OP_LOAD) &&
                        (load_row32 < 32'(MAX_ROWS)) && (load_col32 < 32'(MAX_COLS));
   assign mem_wr_addr = {load_row32[RW-1:0], load_col32[CW-1:0]};

   assign rd_row      = r0_ff + RW'(nb_ff[0]);
   assign rd_col      = c0_ff + CW'(nb_ff[1]);
   assign mem_rd_addr = {rd_row, rd_col};
   assign mem_rd_en   = (state_ff == ST_ADDR);

   brs_image_mem #(
      .ADDR_W (MEM_AW),
      .DEPTH  (DEPTH),
      .DATA_W (brs_pkg::PIX_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (req_tdata[41:18]),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   // range check
   assign rows_eff = (32'(source_rows_ff) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) :
                     32'(source_rows_ff);
   assign cols_eff = (32'(source_cols_ff) > 32'(MAX_COLS)) ? 32'(MAX_COLS) :
                     32'(source_cols_ff);
   assign rows_lim = (rows_eff - 32'd1) << F;
   assign cols_lim = (cols_eff - 32'd1) << F;
   assign row_full = 32'(samp_row_ff) >> F;
   assign col_full = 32'(samp_col_ff) >> F;

   // shared multiplier operands
   assign wr_sel = nb_ff[0] ? {1'b0, wr1_ff} : W_ONE - {1'b0, wr1_ff};
   assign wc_sel = nb_ff[1] ? {1'b0, wc1_ff} : W_ONE - {1'b0, wc1_ff};

   always_comb begin
      unique case (ch_ff)
         2'd0:    chan_sel = mem_rd_data[7:0];
         2'd1:    chan_sel = mem_rd_data[15:8];
         2'd2:    chan_sel = mem_rd_data[23:16];
         default: chan_sel = '0;
      endcase
   end

   always_comb begin
      if (state_ff == ST_MAC) begin
         mul_a      = weight_ff;
         mul_b      = OPB_W'(chan_sel);
         mul_tag_in = '{en: 1'b1, ch: ch_ff};
      end else begin
         mul_a      = WGT_W'(wr_sel);
         mul_b      = OPB_W'(wc_sel);
         mul_tag_in = '{en: 1'b0, ch: 2'd0};
      end
   end

   brs_mul_unit #(
      .A_W (WGT_W),
      .B_W (OPB_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .tag_in  (mul_tag_in),
      .prod_ff (mul_prod),
      .tag_ff  (mul_tag)
   );

   always_comb begin
      for (int i = 0; i < brs_pkg::NUM_CH; i++) begin
         rnd_sum[i] = acc_ff[i] + RND;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      samp_row_in    = samp_row_ff;
      samp_col_in    = samp_col_ff;
      frame_in       = frame_ff;
      outside_in     = outside_ff;
      r0_in          = r0_ff;
      c0_in          = c0_ff;
      wr1_in         = wr1_ff;
      wc1_in         = wc1_ff;
      nb_in          = nb_ff;
      ch_in          = ch_ff;
      weight_in      = weight_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_outside_in = rsp_outside_ff;
      rsp_last_in    = rsp_last_ff;
      for (int i = 0; i < brs_pkg::NUM_CH; i++) begin
         acc_in[i] = acc_ff[i];
         if (mul_tag.en && (mul_tag.ch == 2'(i))) begin
            acc_in[i] = acc_ff[i] + mul_prod[ACC_W-1:0];
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == brs_pkg::OP_SAMPLE)) begin
               samp_row_in = req_tdata[60:42];
               samp_col_in = req_tdata[79:61];
               frame_in    = req_tlast;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            outside_in = samp_row_ff[CW_C-1] || samp_col_ff[CW_C-1] ||
                         (rows_eff < 32'd2) || (cols_eff < 32'd2) ||
                         (32'(samp_row_ff) >= rows_lim) ||
                         (32'(samp_col_ff) >= cols_lim);
            r0_in  = row_full[RW-1:0];
            c0_in  = col_full[CW-1:0];
            wr1_in = samp_row_ff[F-1:0];
            wc1_in = samp_col_ff[F-1:0];
            nb_in  = 2'd0;
            ch_in  = 2'd0;
            for (int i = 0; i < brs_pkg::NUM_CH; i++) begin
               acc_in[i] = '0;
            end
            state_in = outside_in ? ST_DONE : ST_ADDR;
         end
         ST_ADDR: begin
            state_in = ST_WGT;
         end
         ST_WGT: begin
            weight_in = mul_prod[WGT_W-1:0];
            ch_in     = 2'd0;
            state_in  = ST_MAC;
         end
         ST_MAC: begin
            if (ch_ff == 2'd2) begin
               ch_in = 2'd0;
               if (nb_ff == 2'd3) begin
                  state_in = ST_DRAIN;
               end else begin
                  nb_in    = nb_ff + 2'd1;
                  state_in = ST_ADDR;
               end
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_outside_in = outside_ff;
               rsp_last_in    = frame_ff;
               for (int i = 0; i < brs_pkg::NUM_CH; i++) begin
                  rsp_data_in[i*brs_pkg::CH_W +: brs_pkg::CH_W] =
                     outside_ff ? '0 : rnd_sum[i][2*F +: brs_pkg::CH_W];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nb_ff        <= 2'd0;
         ch_ff        <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nb_ff        <= nb_in;
         ch_ff        <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_row_ff    <= samp_row_in;
      samp_col_ff    <= samp_col_in;
      frame_ff       <= frame_in;
      outside_ff     <= outside_in;
      r0_ff          <= r0_in;
      c0_ff          <= c0_in;
      wr1_ff         <= wr1_in;
      wc1_ff         <= wc1_in;
      weight_ff      <= weight_in;
      acc_ff         <= acc_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_outside_ff <= rsp_outside_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_outside_ff;
   assign rsp_tlast    = rsp_last_ff;

endmodule

>>> rtl/brs_image_mem.sv
module brs_image_mem #(
   parameter int ADDR_W = 18,
   parameter int DEPTH  = 262144,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/brs_mul_unit.sv
module brs_mul_unit #(
   parameter int A_W = 17,
   parameter int B_W = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [A_W-1:0]         op_a,
   input  logic [B_W-1:0]         op_b,
   input  brs_pkg::mac_tag_type   tag_in,
   output logic [A_W+B_W-1:0]     prod_ff,
   output brs_pkg::mac_tag_type   tag_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

>>> rtl/brs_checker.sv
module brs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [brs_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [0:0]                     req_tuser,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [brs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                     rsp_tuser,
   input logic                           rsp_tlast,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [brs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [brs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [brs_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                           csr_pready
);

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // outside samples are black
   a_outside_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("outside result not black");

   // a load never creates a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (brs_pkg::op_type'(req_tuser[0]) == brs_pkg::OP_LOAD) &&
       !rsp_tvalid) |=> !rsp_tvalid)
      else $error("load produced a result");

   // a sample blocks the input while in work
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (brs_pkg::op_type'(req_tuser[0]) == brs_pkg::OP_SAMPLE))
      |=> !req_tready)
      else $error("input ready during sample");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind bilinear_remap_sampler_top brs_checker u_brs_checker (.*);
